### hw/rtl/isie_pkg.sv
package isie_pkg;

  // Fixed field widths of the two channels.
  localparam int unsigned OP_W     = 2;
  localparam int unsigned INDEX_W  = 7;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned LENGTH_W = 7;

  // Operation codes carried in the op field.
  typedef enum logic [OP_W-1:0] {
    OP_READ   = 2'd0,
    OP_WRITE  = 2'd1,
    OP_INSERT = 2'd2,
    OP_ERASE  = 2'd3
  } op_e;

  // One operation request.
  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [INDEX_W-1:0] index;
    logic [VALUE_W-1:0] value;
  } in_item_t;

  // One operation result.
  typedef struct packed {
    logic [VALUE_W-1:0]  read_value;
    logic [LENGTH_W-1:0] length;
    logic                error;
  } out_item_t;

  // Command broadcast to every cell of the row.
  typedef struct packed {
    logic               write_en;
    logic               insert_en;
    logic               erase_en;
    logic               read_en;
    logic [INDEX_W-1:0] index;
  } cell_cmd_t;

endpackage

### hw/rtl/isie_cell.sv
module isie_cell #(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned CMP_W      = 7,
  parameter int unsigned POS        = 0
) (
  input  logic                  clk_i,
  input  isie_pkg::cell_cmd_t   upd_i,
  input  isie_pkg::cell_cmd_t   rd_i,
  input  logic [DATA_WIDTH-1:0] value_i,
  input  logic [DATA_WIDTH-1:0] lower_i,
  input  logic [DATA_WIDTH-1:0] upper_i,
  output logic [DATA_WIDTH-1:0] word_o,
  output logic [DATA_WIDTH-1:0] rd_word_o
);
  import isie_pkg::*;

  localparam logic [CMP_W-1:0] MY_POS = CMP_W'(POS);

  logic [DATA_WIDTH-1:0] word_d, word_q;
  logic [CMP_W-1:0]      upd_idx, rd_idx;
  logic                  upd_at, upd_above, rd_at;

  // Compare this cell's fixed position against the broadcast indexes.
  assign upd_idx   = CMP_W'(upd_i.index);
  assign rd_idx    = CMP_W'(rd_i.index);
  assign upd_at    = (upd_idx == MY_POS);
  assign upd_above = (MY_POS > upd_idx);
  assign rd_at     = (rd_idx == MY_POS);

  // Load the new word, shift up from the lower neighbor, or shift down from the upper one.
  always_comb begin
    word_d = word_q;
    if (upd_i.write_en && upd_at) begin
      word_d = value_i;
    end else if (upd_i.insert_en) begin
      if (upd_at) begin
        word_d = value_i;
      end else if (upd_above) begin
        word_d = lower_i;
      end
    end else if (upd_i.erase_en && (upd_at || upd_above)) begin
      word_d = upper_i;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o    = word_q;
  // Only the addressed cell drives its word into the read reduction.
  assign rd_word_o = (rd_i.read_en && rd_at) ? word_q : '0;

endmodule

### hw/rtl/isie_or_tree.sv
module isie_or_tree #(
  parameter int unsigned N = 64,
  parameter int unsigned W = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  logic [N-1:0][W-1:0] data_i,
  output logic                valid_o,
  output logic [W-1:0]        data_o
);
  import isie_pkg::*;

  localparam int unsigned FANIN  = 8;
  localparam int unsigned GROUPS = (N + FANIN - 1) / FANIN;

  if (N <= FANIN) begin : g_leaf
    logic         valid_q;
    logic [W-1:0] or_d, or_q;

    // Last level: combine the remaining inputs into one word.
    always_comb begin
      or_d = '0;
      for (int k = 0; k < N; k++) begin
        or_d = or_d | data_i[k];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q <= 1'b0;
      end else begin
        valid_q <= valid_i;
      end
    end

    always_ff @(posedge clk_i) begin
      or_q <= or_d;
    end

    assign valid_o = valid_q;
    assign data_o  = or_q;
  end else begin : g_node
    logic                     valid_q;
    logic [GROUPS-1:0][W-1:0] grp_d, grp_q;

    // Combine each group of eight inputs and register the partial results.
    always_comb begin
      for (int g = 0; g < GROUPS; g++) begin
        grp_d[g] = '0;
        for (int k = 0; k < FANIN; k++) begin
          if (g * FANIN + k < N) begin
            grp_d[g] = grp_d[g] | data_i[g * FANIN + k];
          end
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q <= 1'b0;
      end else begin
        valid_q <= valid_i;
      end
    end

    always_ff @(posedge clk_i) begin
      grp_q <= grp_d;
    end

    isie_or_tree #(
      .N(GROUPS),
      .W(W)
    ) u_next (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(valid_q),
      .data_i (grp_q),
      .valid_o(valid_o),
      .data_o (data_o)
    );
  end

endmodule

### hw/rtl/indexed_sequence_insert_erase_unit.sv
// Channel | Direction | Handshake                | Payload
// --------+-----------+--------------------------+----------------------------------
// in      | input     | in_valid_i / in_stall_o   | in_item_i  (op, index, value)
// out     | output    | out_valid_o / out_stall_i | out_item_o (read_value, length, error)
//
// Each operation passes from transfer to result through the read command register,
// the registered OR tree that collects the addressed cell's word and the output register;
// one operation is in flight at a time.
// All cells update in the cycle of the input transfer, shifting in parallel.
// Reset clears the element count and the handshake state; the cell words are not reset.
// A waiting result does not block the next transfer unless out_stall_i is high.
module indexed_sequence_insert_erase_unit #(
  parameter int unsigned CAPACITY   = 64,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  isie_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output isie_pkg::out_item_t out_item_o
);
  import isie_pkg::*;

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;
  localparam int unsigned EXT_W = (DATA_WIDTH > VALUE_W) ? DATA_WIDTH : VALUE_W;

  logic                                accept;
  logic [CNT_W-1:0]                    count_d, count_q;
  logic                                busy_d, busy_q;
  logic                                start_q;
  cell_cmd_t                           upd_cmd;
  cell_cmd_t                           rd_cmd_d, rd_cmd_q;
  logic [LENGTH_W-1:0]                 len_d, len_q;
  logic                                err_d, err_q;
  logic [CMP_W-1:0]                    idx_c, cnt_c;
  logic                                in_range, ins_ok;
  logic [EXT_W-1:0]                    value_ext, rd_ext;
  logic [DATA_WIDTH-1:0]               value_w;
  logic [CAPACITY-1:0][DATA_WIDTH-1:0] cell_word;
  logic [CAPACITY-1:0][DATA_WIDTH-1:0] rd_word;
  logic                                tree_valid;
  logic [DATA_WIDTH-1:0]               tree_data;
  logic                                out_valid_d, out_valid_q;
  out_item_t                           out_item_d, out_item_q;

  // Handshake: hold off while an operation is in the read tree or a result is stuck.
  assign in_stall_o = busy_q || (out_valid_q && out_stall_i);
  assign accept     = in_valid_i && !in_stall_o;

  // Range checks against the current length.
  assign idx_c    = CMP_W'(in_item_i.index);
  assign cnt_c    = CMP_W'(count_q);
  assign in_range = (idx_c < cnt_c);
  assign ins_ok   = (idx_c <= cnt_c) && (count_q != CNT_W'(CAPACITY));

  assign value_ext = EXT_W'(in_item_i.value);
  assign value_w   = value_ext[DATA_WIDTH-1:0];

  // Decode the operation into a cell command, the new count and the error flag.
  always_comb begin
    upd_cmd          = '0;
    upd_cmd.index    = in_item_i.index;
    rd_cmd_d         = rd_cmd_q;
    count_d          = count_q;
    err_d            = err_q;
    len_d            = len_q;
    if (accept) begin
      rd_cmd_d       = '0;
      rd_cmd_d.index = in_item_i.index;
      err_d          = 1'b0;
      case (in_item_i.op)
        OP_READ: begin
          rd_cmd_d.read_en = in_range;
          err_d            = !in_range;
        end
        OP_WRITE: begin
          upd_cmd.write_en = in_range;
          err_d            = !in_range;
        end
        OP_INSERT: begin
          upd_cmd.insert_en = ins_ok;
          err_d             = !ins_ok;
          if (ins_ok) begin
            count_d = count_q + CNT_W'(1);
          end
        end
        OP_ERASE: begin
          upd_cmd.erase_en = in_range;
          err_d            = !in_range;
          if (in_range) begin
            count_d = count_q - CNT_W'(1);
          end
        end
        default: begin
          err_d = 1'b1;
        end
      endcase
      len_d = LENGTH_W'(CMP_W'(count_d));
    end
  end

  // Busy from the input transfer until the read tree hands back its word.
  always_comb begin
    busy_d = busy_q;
    if (accept) begin
      busy_d = 1'b1;
    end else if (tree_valid) begin
      busy_d = 1'b0;
    end
  end

  // Output register: loaded from the tree, cleared once the result is taken.
  always_comb begin
    out_valid_d = out_valid_q;
    out_item_d  = out_item_q;
    if (tree_valid) begin
      out_valid_d           = 1'b1;
      out_item_d.read_value = rd_ext[VALUE_W-1:0];
      out_item_d.length     = len_q;
      out_item_d.error      = err_q;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign rd_ext = EXT_W'(tree_data);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      busy_q      <= 1'b0;
      start_q     <= 1'b0;
      out_valid_q <= 1'b0;
      rd_cmd_q    <= '0;
    end else begin
      count_q     <= count_d;
      busy_q      <= busy_d;
      start_q     <= accept;
      out_valid_q <= out_valid_d;
      rd_cmd_q    <= rd_cmd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    len_q      <= len_d;
    err_q      <= err_d;
    out_item_q <= out_item_d;
  end

  // Row of storage cells, each wired to its two neighbors.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] lower, upper;

    if (i == 0) begin : g_first
      assign lower = '0;
    end else begin : g_lower
      assign lower = cell_word[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign upper = '0;
    end else begin : g_upper
      assign upper = cell_word[i+1];
    end

    isie_cell #(
      .DATA_WIDTH(DATA_WIDTH),
      .CMP_W     (CMP_W),
      .POS       (i)
    ) u_cell (
      .clk_i    (clk_i),
      .upd_i    (upd_cmd),
      .rd_i     (rd_cmd_q),
      .value_i  (value_w),
      .lower_i  (lower),
      .upper_i  (upper),
      .word_o   (cell_word[i]),
      .rd_word_o(rd_word[i])
    );
  end

  // Registered reduction of the masked cell words.
  isie_or_tree #(
    .N(CAPACITY),
    .W(DATA_WIDTH)
  ) u_or_tree (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(start_q),
    .data_i (rd_word),
    .valid_o(tree_valid),
    .data_o (tree_data)
  );

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("element count exceeds capacity");

  a_err_keeps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && err_d |=> count_q == $past(count_q))
    else $error("refused operation changed the element count");

  a_tree_into_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tree_valid |-> !out_valid_q)
    else $error("read tree result would overwrite a pending result");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_q && !out_valid_q)
    else $error("transfer did not start an operation");

  a_err_zero_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_item_q.error |-> out_item_q.read_value == '0)
    else $error("refused operation returned a nonzero word");
`endif

endmodule

### bench/indexed_sequence_insert_erase_unit_test.sv
module indexed_sequence_insert_erase_unit_test;
  import isie_pkg::*;

  localparam int unsigned DEPTH        = 64;
  localparam int unsigned PHASE_ITEMS  = 150;
  localparam int unsigned PHASES       = 12;
  localparam int unsigned LONG_HOLD    = 60;
  localparam int unsigned STALL_LIMIT  = 1000;
  localparam int unsigned DRAIN_CYCLES = 8;

  typedef enum int unsigned {
    GROW,
    SHRINK,
    MIXED
  } profile_e;

  // Shadow copy of the sequence. It applies each accepted operation and
  // keeps the results the block owes, oldest first.
  class sequence_shadow;
    logic [VALUE_W-1:0] words [DEPTH];
    int unsigned fill;
    out_item_t owed_results [$];
    int unsigned mismatches;
    int unsigned results_seen;
    int unsigned refusals;
    int unsigned full_refusals;
    int unsigned peak_fill;

    function new();
      fill = 0;
      mismatches = 0;
      results_seen = 0;
      refusals = 0;
      full_refusals = 0;
      peak_fill = 0;
    endfunction

    function void apply_request(in_item_t req);
      out_item_t res;
      int unsigned j;
      res = '0;
      case (op_e'(req.op))
        OP_READ: begin
          if (req.index < fill) res.read_value = words[req.index];
          else res.error = 1'b1;
        end
        OP_WRITE: begin
          if (req.index < fill) words[req.index] = req.value;
          else res.error = 1'b1;
        end
        OP_INSERT: begin
          if (req.index <= fill && fill < DEPTH) begin
            // Later elements move up by one to open the slot.
            for (j = fill; j > req.index; j--) words[j] = words[j-1];
            words[req.index] = req.value;
            fill++;
          end else begin
            res.error = 1'b1;
            if (fill == DEPTH) full_refusals++;
          end
        end
        default: begin
          if (req.index < fill) begin
            // Later elements move down by one to close the gap.
            for (j = req.index; j + 1 < fill; j++) words[j] = words[j+1];
            fill--;
          end else begin
            res.error = 1'b1;
          end
        end
      endcase
      if (res.error) refusals++;
      if (fill > peak_fill) peak_fill = fill;
      res.length = LENGTH_W'(fill);
      owed_results.push_back(res);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      results_seen++;
      if (owed_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected result: read_value=%h length=%0d error=%b",
                   got.read_value, got.length, got.error);
        return;
      end
      want = owed_results.pop_front();
      if (got.read_value !== want.read_value || got.length !== want.length ||
          got.error !== want.error) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Mismatch on result %0d: expected read_value=%h length=%0d error=%b, %s",
                   results_seen, want.read_value, want.length, want.error,
                   $sformatf("got read_value=%h length=%0d error=%b",
                             got.read_value, got.length, got.error));
      end
    endfunction

    function int unsigned pending();
      return owed_results.size();
    endfunction
  endclass

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_item_t  in_item_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_item_o;

  sequence_shadow shadow = new();
  bit no_idle = 1'b0;
  bit long_hold_request = 1'b0;
  int unsigned ops_sent = 0;
  int unsigned idle_cycles = 0;

  indexed_sequence_insert_erase_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Handshake signals only change at the rising edge, so the falling edge
  // sees exactly what the next rising edge will transfer.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) shadow.check_result(out_item_o);
      if (in_valid_i && !in_stall_o) shadow.apply_request(in_item_i);
    end
  end

  // Watchdog: end the run when no transfer happens for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles.", STALL_LIMIT);
      $display("FAIL indexed_sequence_insert_erase_unit");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side: stall for a random number of cycles before each transfer,
  // or for a long stretch when asked to.
  initial begin
    int unsigned hold;
    forever begin
      if (long_hold_request) begin
        hold = LONG_HOLD;
        long_hold_request = 1'b0;
      end else begin
        hold = no_idle ? 0 : $urandom_range(0, 4);
      end
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  // Offer one operation after a random gap and hold it until it transfers.
  task automatic send_request(in_item_t req);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= req;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    ops_sent++;
  endtask

  task automatic send_op(op_e op, int unsigned index, logic [VALUE_W-1:0] value);
    in_item_t req;
    req.op = op;
    req.index = INDEX_W'(index);
    req.value = value;
    send_request(req);
  endtask

  // Stop offering until every owed result has come back.
  task automatic wait_until_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (shadow.pending() != 0) @(posedge clk_i);
  endtask

  // Random operation biased by profile; most indexes land inside the sequence.
  function automatic in_item_t random_request(profile_e profile);
    in_item_t req;
    int unsigned roll;
    int unsigned top;
    roll = $urandom_range(0, 99);
    case (profile)
      GROW:    req.op = roll < 55 ? OP_INSERT : roll < 70 ? OP_READ :
                        roll < 85 ? OP_WRITE : OP_ERASE;
      SHRINK:  req.op = roll < 50 ? OP_ERASE : roll < 70 ? OP_READ :
                        roll < 85 ? OP_WRITE : OP_INSERT;
      default: req.op = roll < 25 ? OP_READ : roll < 50 ? OP_WRITE :
                        roll < 75 ? OP_INSERT : OP_ERASE;
    endcase
    if (req.op == OP_INSERT) top = shadow.fill;
    else top = shadow.fill == 0 ? 0 : shadow.fill - 1;
    roll = $urandom_range(0, 99);
    if (roll < 80) req.index = INDEX_W'($urandom_range(0, top));
    else if (roll < 88) req.index = INDEX_W'(top);
    else if (roll < 92) req.index = '0;
    else if (roll < 96) req.index = INDEX_W'(top + 1);
    else req.index = INDEX_W'($urandom_range(0, 127));
    roll = $urandom_range(0, 99);
    if (roll < 5) req.value = '0;
    else if (roll < 10) req.value = '1;
    else req.value = $urandom;
    return req;
  endfunction

  // Main sequence: reset, directed corner cases, then random phases.
  initial begin
    profile_e profile;
    int unsigned phase;
    int unsigned n;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Every operation on an empty sequence is refused.
    send_op(OP_READ, 0, 32'h0);
    send_op(OP_ERASE, 0, 32'h0);
    send_op(OP_WRITE, 0, 32'hFFFF_FFFF);
    send_op(OP_INSERT, 1, 32'h1111_1111);
    // Build a short sequence: append, front insert and middle insert.
    send_op(OP_INSERT, 0, 32'hFFFF_FFFF);
    send_op(OP_INSERT, 1, 32'h0000_0000);
    send_op(OP_INSERT, 0, 32'hA5A5_A5A5);
    send_op(OP_INSERT, 1, 32'h5A5A_5A5A);
    send_op(OP_READ, 0, 32'h0);
    send_op(OP_READ, 1, 32'h0);
    send_op(OP_READ, 2, 32'h0);
    send_op(OP_READ, 3, 32'h0);
    // Overwrite the last element, then one past the end.
    send_op(OP_WRITE, 3, 32'h1234_5678);
    send_op(OP_WRITE, 4, 32'h8765_4321);
    // Indexes far out of range, with the top index bit set.
    send_op(OP_READ, 127, 32'h0);
    send_op(OP_INSERT, 127, 32'hDEAD_BEEF);
    send_op(OP_INSERT, 64, 32'hDEAD_BEEF);
    // Erase in the middle, at the end and at the front.
    send_op(OP_ERASE, 1, 32'h0);
    send_op(OP_ERASE, 2, 32'h0);
    send_op(OP_ERASE, 0, 32'h0);
    send_op(OP_READ, 0, 32'h0);
    send_op(OP_ERASE, 1, 32'h0);
    wait_until_drained();

    // Random phases: grow to full, churn, shrink to empty, and again.
    for (phase = 0; phase < PHASES; phase++) begin
      case (phase % 6)
        0, 1:    profile = GROW;
        3, 4:    profile = SHRINK;
        default: profile = MIXED;
      endcase
      no_idle = (phase % 5 == 2);
      if (phase == 3 || phase == 9) long_hold_request = 1'b1;
      for (n = 0; n < PHASE_ITEMS; n++) send_request(random_request(profile));
      if (phase % 3 == 2) wait_until_drained();
    end
    no_idle = 1'b0;

    wait_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d operations, %0d refused (%0d inserts into a full sequence).",
             ops_sent, shadow.refusals, shadow.full_refusals);
    $display("Checked %0d results; peak length %0d, %0d mismatches.",
             shadow.results_seen, shadow.peak_fill, shadow.mismatches);
    if (shadow.mismatches == 0 && shadow.pending() == 0) begin
      $display("PASS indexed_sequence_insert_erase_unit");
    end else begin
      $display("FAIL indexed_sequence_insert_erase_unit");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/isie_pkg.sv
hw/rtl/isie_cell.sv
hw/rtl/isie_or_tree.sv
hw/rtl/indexed_sequence_insert_erase_unit.sv
bench/indexed_sequence_insert_erase_unit_test.sv
